// ----- design/caes_pkg.sv -----
`timescale 1ns / 1ps
package caes_pkg;

	localparam int CW = 32;
	localparam int FRAC_BITS = 16;
	localparam int NREG = 16;
	localparam int STEP_W = 17;
	localparam int PC_W = 6;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_NEG  = 3'd3,
		OP_SHL2 = 3'd4,
		OP_PHS  = 3'd5,
		OP_CNEG = 3'd6,
		OP_END  = 3'd7
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] dst;
		logic [5:0] a;
		logic [5:0] b;
	} instr_t;

	typedef struct packed {
		logic       start;
		logic       load_we;
		logic [1:0] load_idx;
		logic       ex;
		logic       wb;
		logic       tail;
		logic       out_load;
		instr_t     instr;
	} cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       out_busy;
	} stat_t;

	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_STEP = 2'd1;

	// operand codes: registers, step size, constants
	localparam logic [5:0] S_X = 6'd0, S_Y = 6'd1, S_Z = 6'd2;
	localparam logic [5:0] S_D0 = 6'd3, S_D1 = 6'd4, S_D2 = 6'd5;
	localparam logic [5:0] S_T6 = 6'd6, S_T7 = 6'd7, S_T8 = 6'd8, S_T9 = 6'd9;
	localparam logic [5:0] S_T10 = 6'd10, S_T12 = 6'd12, S_T13 = 6'd13, S_T14 = 6'd14;
	localparam logic [5:0] S_STEP = 6'd16;
	localparam logic [5:0] K_ONE = 6'd32, K_10 = 6'd33, K_28 = 6'd34, K_8_3 = 6'd35;
	localparam logic [5:0] K_THIRD = 6'd36, K_TH = 6'd37, K_SINC = 6'd38, K_0225 = 6'd39;
	localparam logic [5:0] K_07 = 6'd40, K_35 = 6'd41, K_06 = 6'd42, K_095 = 6'd43;
	localparam logic [5:0] K_025 = 6'd44, K_01 = 6'd45, K_3 = 6'd46, K_27 = 6'd47;
	localparam logic [5:0] K_17 = 6'd48, K_2 = 6'd49, K_9 = 6'd50, K_5 = 6'd51;
	localparam logic [5:0] K_038 = 6'd52, K_189 = 6'd53, K_4 = 6'd54, K_014 = 6'd55;
	localparam logic [5:0] K_3248 = 6'd56, K_013 = 6'd57, K_4584 = 6'd58, K_147 = 6'd59;
	localparam logic [5:0] K_118 = 6'd60, K_057 = 6'd61;

	function automatic logic signed [CW-1:0] kconst(input logic [4:0] k);
		logic signed [CW-1:0] v;
		case (k)
			5'd0:  v = 32'sd65536;
			5'd1:  v = 32'sd655360;
			5'd2:  v = 32'sd1835008;
			5'd3:  v = 32'sd174763;
			5'd4:  v = 32'sd21845;
			5'd5:  v = 32'sd13644;
			5'd6:  v = 32'sd10430;
			5'd7:  v = 32'sd14746;
			5'd8:  v = 32'sd45875;
			5'd9:  v = 32'sd229376;
			5'd10: v = 32'sd39322;
			5'd11: v = 32'sd62259;
			5'd12: v = 32'sd16384;
			5'd13: v = 32'sd6554;
			5'd14: v = 32'sd196608;
			5'd15: v = 32'sd176947;
			5'd16: v = 32'sd111411;
			5'd17: v = 32'sd131072;
			5'd18: v = 32'sd589824;
			5'd19: v = 32'sd327680;
			5'd20: v = 32'sd24904;
			5'd21: v = 32'sd123863;
			5'd22: v = 32'sd262144;
			5'd23: v = 32'sd9175;
			5'd24: v = 32'sd2128609;
			5'd25: v = 32'sd8520;
			5'd26: v = 32'sd3004170;
			5'd27: v = 32'sd963379;
			5'd28: v = 32'sd77332;
			5'd29: v = 32'sd37356;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [CW-1:0] preset(input logic [2:0] m, input logic [1:0] i);
		logic signed [CW-1:0] v;
		case ({m, i})
			5'b000_00: v = 32'sd72090;
			5'b000_01: v = 32'sd65536;
			5'b000_10: v = 32'sd65536;
			5'b001_00: v = 32'sd72090;
			5'b001_01: v = 32'sd72090;
			5'b001_10: v = -32'sd655;
			5'b010_00: v = 32'sd6554;
			5'b010_01: v = 32'sd65536;
			5'b010_10: v = 32'sd655;
			5'b011_00: v = 32'sd72090;
			5'b011_01: v = 32'sd137626;
			5'b011_10: v = -32'sd131072;
			5'b100_00: v = 32'sd327680;
			5'b100_01: v = 32'sd655360;
			5'b100_10: v = 32'sd655360;
			5'b101_00: v = -32'sd96993;
			5'b101_01: v = -32'sd98959;
			5'b101_10: v = 32'sd133693;
			5'b110_00: v = -32'sd65536;
			5'b110_01: v = 32'sd0;
			5'b110_10: v = 32'sd32768;
			5'b111_00: v = -32'sd19005;
			5'b111_01: v = -32'sd16384;
			5'b111_10: v = -32'sd38666;
			default:   v = '0;
		endcase
		return v;
	endfunction

	function automatic instr_t mk(input op_t op, input logic [5:0] d,
	                              input logic [5:0] a, input logic [5:0] b);
		instr_t r;
		r.op = op;
		r.dst = d[3:0];
		r.a = a;
		r.b = b;
		return r;
	endfunction

	// one sine: phase, parabola, correction, sign of the half turn
	function automatic instr_t sin_step(input logic [PC_W-1:0] j, input logic [5:0] a,
	                                    input logic [5:0] d);
		instr_t r;
		case (j)
			6'd0: r = mk(OP_MUL, S_T12, a, K_SINC);
			6'd1: r = mk(OP_PHS, S_T12, S_T12, S_T12);
			6'd2: r = mk(OP_SHL2, S_T13, S_T12, S_T12);
			6'd3: r = mk(OP_SUB, S_T14, K_ONE, S_T12);
			6'd4: r = mk(OP_MUL, S_T13, S_T13, S_T14);
			6'd5: r = mk(OP_MUL, S_T14, S_T13, S_T13);
			6'd6: r = mk(OP_SUB, S_T14, S_T14, S_T13);
			6'd7: r = mk(OP_MUL, S_T14, K_0225, S_T14);
			6'd8: r = mk(OP_ADD, S_T13, S_T13, S_T14);
			default: r = mk(OP_CNEG, d, S_T13, S_T13);
		endcase
		return r;
	endfunction

	function automatic instr_t halv_step(input logic [PC_W-1:0] j, input logic [5:0] a,
	                                     input logic [5:0] b, input logic [5:0] c,
	                                     input logic [5:0] d);
		instr_t r;
		case (j)
			6'd0: r = mk(OP_MUL, S_T6, K_189, a);
			6'd1: r = mk(OP_NEG, S_T6, S_T6, S_T6);
			6'd2: r = mk(OP_MUL, S_T7, K_4, b);
			6'd3: r = mk(OP_SUB, S_T6, S_T6, S_T7);
			6'd4: r = mk(OP_MUL, S_T7, K_4, c);
			6'd5: r = mk(OP_SUB, S_T6, S_T6, S_T7);
			6'd6: r = mk(OP_MUL, S_T7, b, b);
			default: r = mk(OP_SUB, d, S_T6, S_T7);
		endcase
		return r;
	endfunction

	function automatic instr_t prog(input logic [2:0] m, input logic [PC_W-1:0] pc);
		instr_t r;
		r = mk(OP_END, S_X, S_X, S_X);
		case (m)
			3'd0: begin
				case (pc)
					6'd0: r = mk(OP_SUB, S_T6, S_Y, S_X);
					6'd1: r = mk(OP_MUL, S_D0, K_10, S_T6);
					6'd2: r = mk(OP_SUB, S_T6, K_28, S_Z);
					6'd3: r = mk(OP_MUL, S_T6, S_X, S_T6);
					6'd4: r = mk(OP_SUB, S_D1, S_T6, S_Y);
					6'd5: r = mk(OP_MUL, S_T6, S_X, S_Y);
					6'd6: r = mk(OP_MUL, S_T7, K_8_3, S_Z);
					6'd7: r = mk(OP_SUB, S_D2, S_T6, S_T7);
					default: r = mk(OP_END, S_X, S_X, S_X);
				endcase
			end
			3'd1: begin
				if (pc < 6'd10) r = sin_step(pc, S_Y, S_T6);
				else if (pc == 6'd10) r = mk(OP_MUL, S_T7, K_TH, S_X);
				else if (pc == 6'd11) r = mk(OP_SUB, S_D0, S_T6, S_T7);
				else if (pc < 6'd22) r = sin_step(pc - 6'd12, S_Z, S_T6);
				else if (pc == 6'd22) r = mk(OP_MUL, S_T7, K_TH, S_Y);
				else if (pc == 6'd23) r = mk(OP_SUB, S_D1, S_T6, S_T7);
				else if (pc < 6'd34) r = sin_step(pc - 6'd24, S_X, S_T6);
				else if (pc == 6'd34) r = mk(OP_MUL, S_T7, K_TH, S_Z);
				else if (pc == 6'd35) r = mk(OP_SUB, S_D2, S_T6, S_T7);
			end
			3'd2: begin
				case (pc)
					6'd0:  r = mk(OP_SUB, S_T6, S_Z, K_07);
					6'd1:  r = mk(OP_MUL, S_T7, S_T6, S_X);
					6'd2:  r = mk(OP_MUL, S_T8, K_35, S_Y);
					6'd3:  r = mk(OP_SUB, S_D0, S_T7, S_T8);
					6'd4:  r = mk(OP_MUL, S_T7, K_35, S_X);
					6'd5:  r = mk(OP_MUL, S_T8, S_T6, S_Y);
					6'd6:  r = mk(OP_ADD, S_D1, S_T7, S_T8);
					6'd7:  r = mk(OP_MUL, S_T7, K_095, S_Z);
					6'd8:  r = mk(OP_ADD, S_T7, K_06, S_T7);
					6'd9:  r = mk(OP_MUL, S_T8, S_Z, S_Z);
					6'd10: r = mk(OP_MUL, S_T8, S_T8, S_Z);
					6'd11: r = mk(OP_MUL, S_T8, S_T8, K_THIRD);
					6'd12: r = mk(OP_SUB, S_T7, S_T7, S_T8);
					6'd13: r = mk(OP_MUL, S_T8, S_X, S_X);
					6'd14: r = mk(OP_MUL, S_T9, S_Y, S_Y);
					6'd15: r = mk(OP_ADD, S_T9, S_T8, S_T9);
					6'd16: r = mk(OP_MUL, S_T10, K_025, S_Z);
					6'd17: r = mk(OP_ADD, S_T10, K_ONE, S_T10);
					6'd18: r = mk(OP_MUL, S_T9, S_T9, S_T10);
					6'd19: r = mk(OP_SUB, S_T7, S_T7, S_T9);
					6'd20: r = mk(OP_MUL, S_T10, K_01, S_Z);
					6'd21: r = mk(OP_MUL, S_T8, S_T8, S_X);
					6'd22: r = mk(OP_MUL, S_T10, S_T10, S_T8);
					6'd23: r = mk(OP_ADD, S_D2, S_T7, S_T10);
					default: r = mk(OP_END, S_X, S_X, S_X);
				endcase
			end
			3'd3: begin
				case (pc)
					6'd0:  r = mk(OP_MUL, S_T6, K_3, S_X);
					6'd1:  r = mk(OP_SUB, S_T6, S_Y, S_T6);
					6'd2:  r = mk(OP_MUL, S_T7, K_27, S_Y);
					6'd3:  r = mk(OP_MUL, S_T7, S_T7, S_Z);
					6'd4:  r = mk(OP_ADD, S_D0, S_T6, S_T7);
					6'd5:  r = mk(OP_MUL, S_T6, K_17, S_Y);
					6'd6:  r = mk(OP_MUL, S_T7, S_X, S_Z);
					6'd7:  r = mk(OP_SUB, S_T6, S_T6, S_T7);
					6'd8:  r = mk(OP_ADD, S_D1, S_T6, S_Z);
					6'd9:  r = mk(OP_MUL, S_T6, K_2, S_X);
					6'd10: r = mk(OP_MUL, S_T6, S_T6, S_Y);
					6'd11: r = mk(OP_MUL, S_T7, K_9, S_Z);
					6'd12: r = mk(OP_SUB, S_D2, S_T6, S_T7);
					default: r = mk(OP_END, S_X, S_X, S_X);
				endcase
			end
			3'd4: begin
				case (pc)
					6'd0:  r = mk(OP_MUL, S_T6, K_5, S_X);
					6'd1:  r = mk(OP_MUL, S_T7, S_Y, S_Z);
					6'd2:  r = mk(OP_SUB, S_D0, S_T6, S_T7);
					6'd3:  r = mk(OP_MUL, S_T6, S_X, S_Z);
					6'd4:  r = mk(OP_MUL, S_T7, K_10, S_Y);
					6'd5:  r = mk(OP_SUB, S_D1, S_T6, S_T7);
					6'd6:  r = mk(OP_MUL, S_T6, S_X, S_Y);
					6'd7:  r = mk(OP_MUL, S_T6, S_T6, K_THIRD);
					6'd8:  r = mk(OP_MUL, S_T7, K_038, S_Z);
					6'd9:  r = mk(OP_SUB, S_D2, S_T6, S_T7);
					default: r = mk(OP_END, S_X, S_X, S_X);
				endcase
			end
			3'd5: begin
				if (pc < 6'd8) r = halv_step(pc, S_X, S_Y, S_Z, S_D0);
				else if (pc < 6'd16) r = halv_step(pc - 6'd8, S_Y, S_Z, S_X, S_D1);
				else if (pc < 6'd24) r = halv_step(pc - 6'd16, S_Z, S_X, S_Y, S_D2);
			end
			3'd6: begin
				case (pc)
					6'd0:  r = mk(OP_MUL, S_T8, S_X, S_X);
					6'd1:  r = mk(OP_SUB, S_T6, S_Z, K_ONE);
					6'd2:  r = mk(OP_ADD, S_T6, S_T6, S_T8);
					6'd3:  r = mk(OP_MUL, S_T6, S_Y, S_T6);
					6'd4:  r = mk(OP_MUL, S_T7, K_01, S_X);
					6'd5:  r = mk(OP_ADD, S_D0, S_T6, S_T7);
					6'd6:  r = mk(OP_MUL, S_T6, K_3, S_Z);
					6'd7:  r = mk(OP_ADD, S_T6, S_T6, K_ONE);
					6'd8:  r = mk(OP_SUB, S_T6, S_T6, S_T8);
					6'd9:  r = mk(OP_MUL, S_T6, S_X, S_T6);
					6'd10: r = mk(OP_MUL, S_T7, K_01, S_Y);
					6'd11: r = mk(OP_ADD, S_D1, S_T6, S_T7);
					6'd12: r = mk(OP_MUL, S_T6, K_2, S_Z);
					6'd13: r = mk(OP_MUL, S_T7, S_X, S_Y);
					6'd14: r = mk(OP_ADD, S_T7, K_014, S_T7);
					6'd15: r = mk(OP_MUL, S_T6, S_T6, S_T7);
					6'd16: r = mk(OP_NEG, S_D2, S_T6, S_T6);
					default: r = mk(OP_END, S_X, S_X, S_X);
				endcase
			end
			default: begin
				case (pc)
					6'd0:  r = mk(OP_SUB, S_T6, S_Y, S_X);
					6'd1:  r = mk(OP_MUL, S_T6, K_3248, S_T6);
					6'd2:  r = mk(OP_MUL, S_T7, K_013, S_X);
					6'd3:  r = mk(OP_MUL, S_T7, S_T7, S_Y);
					6'd4:  r = mk(OP_ADD, S_D0, S_T6, S_T7);
					6'd5:  r = mk(OP_MUL, S_T6, K_4584, S_X);
					6'd6:  r = mk(OP_MUL, S_T7, S_X, S_Z);
					6'd7:  r = mk(OP_SUB, S_T6, S_T6, S_T7);
					6'd8:  r = mk(OP_MUL, S_T7, K_147, S_Y);
					6'd9:  r = mk(OP_ADD, S_D1, S_T6, S_T7);
					6'd10: r = mk(OP_MUL, S_T6, K_118, S_Z);
					6'd11: r = mk(OP_MUL, S_T7, S_X, S_Y);
					6'd12: r = mk(OP_ADD, S_T6, S_T6, S_T7);
					6'd13: r = mk(OP_MUL, S_T7, S_X, S_X);
					6'd14: r = mk(OP_MUL, S_T7, K_057, S_T7);
					6'd15: r = mk(OP_SUB, S_D2, S_T6, S_T7);
					default: r = mk(OP_END, S_X, S_X, S_X);
				endcase
			end
		endcase
		return r;
	endfunction

	// euler update, shared by every system; the adds land in the result registers
	function automatic instr_t tail_prog(input logic [PC_W-1:0] pc);
		instr_t r;
		case (pc)
			6'd0: r = mk(OP_MUL, S_D0, S_STEP, S_D0);
			6'd1: r = mk(OP_ADD, S_D0, S_X, S_D0);
			6'd2: r = mk(OP_MUL, S_D1, S_STEP, S_D1);
			6'd3: r = mk(OP_ADD, S_D1, S_Y, S_D1);
			6'd4: r = mk(OP_MUL, S_D2, S_STEP, S_D2);
			6'd5: r = mk(OP_ADD, S_D2, S_Z, S_D2);
			default: r = mk(OP_END, S_X, S_X, S_X);
		endcase
		return r;
	endfunction

endpackage

// ----- design/chaotic_attractor_euler_step_top.sv -----
`timescale 1ns / 1ps
// sequence: load the three coordinates, then read, execute and write back each micro-step on one
// shared multiplier/adder until the program ends, run the euler update and hand the result off;
// N = 8..36 steps per system; a new request is taken only in idle, one request at a time, as set
// by the register file and the single shared unit; the hand-off waits while a result is unread
// a finished result waits in the output register while the next request runs
// reset: mode 0 (lorenz), step 655, stored point at the lorenz start point, no result pending
module chaotic_attractor_euler_step_top import caes_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [STEP_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] z_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic signed [CW-1:0] z_out,
	output logic                 saturated
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	caes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	caes_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.kind      (kind),
		.x_in      (x_in),
		.y_in      (y_in),
		.z_in      (z_in),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_out     (x_out),
		.y_out     (y_out),
		.z_out     (z_out),
		.saturated (saturated)
	);

endmodule

// ----- design/caes_ctrl.sv -----
`timescale 1ns / 1ps
module caes_ctrl import caes_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_RD   = 6'b000100,
		S_EX   = 6'b001000,
		S_WB   = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	logic [PC_W-1:0] pc_q;
	logic tail_q;
	logic [1:0] lcnt_q;
	instr_t instr;

	assign instr = tail_q ? tail_prog(pc_q) : prog(stat.mode, pc_q);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.start = in_valid && in_ready;
		cmd.load_we = (state_q == S_LOAD);
		cmd.load_idx = lcnt_q;
		cmd.ex = (state_q == S_EX);
		cmd.wb = (state_q == S_WB);
		cmd.tail = tail_q;
		cmd.out_load = (state_q == S_DONE) && !stat.out_busy;
		cmd.instr = instr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			tail_q <= 1'b0;
			lcnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOAD;
						lcnt_q <= '0;
					end
				end
				S_LOAD: begin
					lcnt_q <= lcnt_q + 2'd1;
					if (lcnt_q == 2'd2) begin
						state_q <= S_RD;
						pc_q <= '0;
						tail_q <= 1'b0;
					end
				end
				S_RD: begin
					if (instr.op == OP_END) begin
						if (tail_q) begin
							state_q <= S_DONE;
						end else begin
							tail_q <= 1'b1;
							pc_q <= '0;
						end
					end else begin
						state_q <= S_EX;
					end
				end
				S_EX: state_q <= S_WB;
				S_WB: begin
					pc_q <= pc_q + 1'b1;
					state_q <= S_RD;
				end
				S_DONE: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
						tail_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_LOAD)
		else $error("accepted request did not start loading");
	a_idle_no_tail: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !tail_q)
		else $error("tail flag left set in idle");
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= 6'd36)
		else $error("program counter ran past the longest program");
	a_load_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD && lcnt_q == 2'd2 |=> state_q == S_RD && pc_q == '0)
		else $error("program did not start at its first step");

endmodule

// ----- design/caes_dp.sv -----
`timescale 1ns / 1ps
module caes_dp import caes_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [STEP_W-1:0]    cfg_data,
	input  logic                 kind,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic signed [CW-1:0] z_in,
	input  cmd_t                 cmd,
	output stat_t                stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [CW-1:0] x_out,
	output logic signed [CW-1:0] y_out,
	output logic signed [CW-1:0] z_out,
	output logic                 saturated
);

	localparam int SW = CW + 2;
	localparam int PW = 2 * CW;
	localparam int QW = PW - FRAC_BITS;
	localparam logic signed [SW-1:0] SUM_MAX = {3'b000, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {3'b111, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [QW-1:0] LIM_POS = {{(QW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic [QW-1:0] LIM_NEG = {{(QW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

	logic [2:0] mode_q;
	logic [STEP_W-1:0] step_q;
	logic kind_q;
	logic signed [CW-1:0] in_q [3];
	logic signed [CW-1:0] cur_q [3];
	logic signed [CW-1:0] res_q [3];
	logic signed [CW-1:0] rf [NREG];
	logic signed [CW-1:0] rda_q, rdb_q;
	logic signed [CW-1:0] opa, opb, wd, res;
	logic [3:0] wa;
	logic we;
	logic [CW-1:0] ma, mb;
	logic [PW-1:0] prod_s1;
	logic neg_s1;
	logic signed [SW-1:0] sum_s1;
	logic flag_q, clip_q, out_valid_q;
	logic [QW-1:0] q;
	logic over_m, over_p;
	logic signed [CW-1:0] mres, sres;
	logic [1:0] ridx;

	function automatic logic signed [CW-1:0] operand(input logic [5:0] s,
	                                                  input logic signed [CW-1:0] rd,
	                                                  input logic [STEP_W-1:0] st);
		logic signed [CW-1:0] v;
		if (s[5]) v = kconst(s[4:0]);
		else if (s[4]) v = {{(CW-STEP_W){1'b0}}, st};
		else v = rd;
		return v;
	endfunction

	assign stat.mode = mode_q;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign opa = operand(cmd.instr.a, rda_q, step_q);
	assign opb = operand(cmd.instr.b, rdb_q, step_q);
	assign ma = opa[CW-1] ? (~opa + 1'b1) : opa;
	assign mb = opb[CW-1] ? (~opb + 1'b1) : opb;

	// multiply: truncate magnitude, then clip against the signed limit
	assign q = prod_s1[PW-1:FRAC_BITS];
	assign over_m = q > (neg_s1 ? LIM_NEG : LIM_POS);
	assign mres = over_m ? (neg_s1 ? VMIN : VMAX)
	                     : (neg_s1 ? -q[CW-1:0] : q[CW-1:0]);
	assign over_p = (sum_s1 > SUM_MAX) || (sum_s1 < SUM_MIN);
	assign sres = (sum_s1 > SUM_MAX) ? VMAX :
	              (sum_s1 < SUM_MIN) ? VMIN : sum_s1[CW-1:0];
	assign res = (cmd.instr.op == OP_MUL) ? mres : sres;

	assign we = cmd.load_we || cmd.wb;
	assign wa = cmd.load_we ? {2'b00, cmd.load_idx} : cmd.instr.dst;
	assign wd = cmd.load_we ? (kind_q ? in_q[cmd.load_idx] : cur_q[cmd.load_idx]) : res;
	assign ridx = 2'(cmd.instr.dst[2:0] - 3'd3);

	always_ff @(posedge clk) begin
		if (we) rf[wa] <= wd;
		rda_q <= rf[cmd.instr.a[3:0]];
		rdb_q <= rf[cmd.instr.b[3:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			in_q[0] <= x_in;
			in_q[1] <= y_in;
			in_q[2] <= z_in;
		end
		if (cmd.ex) begin
			prod_s1 <= PW'(ma) * PW'(mb);
			neg_s1 <= opa[CW-1] ^ opb[CW-1];
			case (cmd.instr.op)
				OP_ADD:  sum_s1 <= SW'(opa) + SW'(opb);
				OP_SUB:  sum_s1 <= SW'(opa) - SW'(opb);
				OP_NEG:  sum_s1 <= -SW'(opa);
				OP_SHL2: sum_s1 <= SW'(opa) <<< 2;
				OP_PHS:  sum_s1 <= {{(SW-FRAC_BITS){1'b0}}, opa[FRAC_BITS-2:0], 1'b0};
				OP_CNEG: sum_s1 <= flag_q ? -SW'(opa) : SW'(opa);
				default: sum_s1 <= '0;
			endcase
			if (cmd.instr.op == OP_PHS) flag_q <= opa[FRAC_BITS-1];
		end
		if (cmd.wb && cmd.tail && cmd.instr.op == OP_ADD) res_q[ridx] <= res;
		if (cmd.out_load) begin
			x_out <= res_q[0];
			y_out <= res_q[1];
			z_out <= res_q[2];
			saturated <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'd0;
			step_q <= 17'd655;
			for (int i = 0; i < 3; i++) cur_q[i] <= preset(3'd0, 2'(i));
			clip_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == CFG_MODE) begin
				mode_q <= cfg_data[2:0];
				for (int i = 0; i < 3; i++) cur_q[i] <= preset(cfg_data[2:0], 2'(i));
			end else if (cfg_valid && cfg_index == CFG_STEP) begin
				step_q <= cfg_data;
			end
			if (cmd.wb && cmd.tail && cmd.instr.op == OP_ADD && !kind_q) cur_q[ridx] <= res;
			if (cmd.start) clip_q <= 1'b0;
			else if (cmd.wb && ((cmd.instr.op == OP_MUL) ? over_m : over_p)) clip_q <= 1'b1;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result overwrote an unread one");
	a_clip_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !clip_q)
		else $error("saturation flag not cleared for new request");
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_we && cmd.wb))
		else $error("register file write port claimed twice");

endmodule
